FILE: hw/rtl/lcsm_pkg.sv
package lcsm_pkg;

  localparam int DEF_NUM_DISKS   = 8;
  localparam int DEF_SECTOR_BITS = 48;

  localparam int SECTOR_W = 48;
  localparam int LEN_W    = 23;
  localparam int DISK_W   = 3;
  localparam int CFG_W    = 4;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED  = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BARRIER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_MAP     = 2'd0,
    K_BARRIER = 2'd1,
    K_LOAD    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_LOAD   = 2'd1,
    B_SEARCH = 2'd2,
    B_PIECE  = 2'd3
  } back_state_e;

  typedef struct packed {
    kind_e               kind;
    logic [SECTOR_W-1:0] sector;
    logic [LEN_W-1:0]    length;
    logic [DISK_W-1:0]   index;
    logic [SECTOR_W-1:0] size;
    logic [SECTOR_W-1:0] offset;
  } item_t;

endpackage

FILE: hw/rtl/lcsm_if.sv
interface lcsm_req_if;
  import lcsm_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [SECTOR_W-1:0] start_lba;
  logic [LEN_W-1:0]    length_sectors;
  logic                barrier;
  logic [DISK_W-1:0]   disk_index;
  logic [SECTOR_W-1:0] disk_size;
  logic [SECTOR_W-1:0] disk_offset;

  modport source (
    output valid, action, start_lba, length_sectors, barrier, disk_index, disk_size,
           disk_offset,
    input  ready
  );
  modport sink (
    input  valid, action, start_lba, length_sectors, barrier, disk_index, disk_size,
           disk_offset,
    output ready
  );
endinterface

interface lcsm_rsp_if;
  import lcsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DISK_W-1:0]   disk;
  logic [SECTOR_W-1:0] device_sector;
  logic [LEN_W-1:0]    piece_sectors;
  logic                last;

  modport source (
    output valid, status, disk, device_sector, piece_sectors, last,
    input  ready
  );
  modport sink (
    input  valid, status, disk, device_sector, piece_sectors, last,
    output ready
  );
endinterface

FILE: hw/rtl/lcsm_front.sv
module lcsm_front #(
  parameter int NumDisks = lcsm_pkg::DEF_NUM_DISKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcsm_req_if.sink          req_i,
  output lcsm_pkg::item_t   head_o,
  output logic              head_valid_o,
  input  logic              head_pop_i
);
  import lcsm_pkg::*;

  localparam int QDepth = 2;
  localparam int CntW   = $clog2(QDepth + 1);

  item_t           mem_q [QDepth];
  logic            wr_q, wr_d;
  logic            rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  item_t           item;
  logic            keep;
  logic            push;

  always_comb begin
    item.sector = req_i.start_lba;
    item.length = req_i.length_sectors;
    item.index  = req_i.disk_index;
    item.size   = req_i.disk_size;
    item.offset = req_i.disk_offset;
    if (req_i.action) begin
      item.kind = K_LOAD;
    end else if (req_i.barrier) begin
      item.kind = K_BARRIER;
    end else begin
      item.kind = K_MAP;
    end
    // drop loads aimed past the table
    keep = !req_i.action || (int'(req_i.disk_index) < NumDisks);
  end

  assign req_i.ready  = (cnt_q != CntW'(QDepth));
  assign push         = req_i.valid && req_i.ready && keep;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = head_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + CntW'(push) - CntW'(head_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(QDepth)) && !head_pop_i |=> (cnt_q == CntW'(QDepth)))
    else $error("queue count slipped while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !head_pop_i |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count lost a transfer");

endmodule

FILE: hw/rtl/lcsm_back.sv
module lcsm_back #(
  parameter int NumDisks   = lcsm_pkg::DEF_NUM_DISKS,
  parameter int SectorBits = lcsm_pkg::DEF_SECTOR_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lcsm_pkg::item_t            head_i,
  input  logic                       head_valid_i,
  output logic                       head_pop_o,
  input  logic [lcsm_pkg::CFG_W-1:0] disk_count_i,
  lcsm_rsp_if.source                 rsp_o
);
  import lcsm_pkg::*;

  localparam int IdxW = (NumDisks > 1) ? $clog2(NumDisks) : 1;
  localparam int SB   = SectorBits;

  back_state_e state_q, state_d;

  logic [SB-1:0]   end_q   [NumDisks];
  logic [SB-1:0]   first_q [NumDisks];
  logic [SB-1:0]   base_q  [NumDisks];
  logic [NumDisks-1:0] bad_q;

  logic [IdxW-1:0] ld_idx_q;
  logic [SB-1:0]   ld_end_q, ld_os_q, ld_size_q;

  logic [SB-1:0]    sector_q;
  logic [LEN_W-1:0] remain_q;
  logic [SB:0]      sum_q;
  logic [IdxW-1:0]  d_q;
  logic             found_q;

  logic                out_vq;
  status_e             st_q;
  logic [DISK_W-1:0]   dk_q;
  logic [SECTOR_W-1:0] dev_q;
  logic [LEN_W-1:0]    pc_q;
  logic                last_q;

  logic [SB-1:0]   head_sect, head_size, head_off;
  logic [IdxW-1:0] hd_idx, rd_addr;
  logic [SB-1:0]   end_rd, prev_end, end_n, os_n;
  logic [SB:0]     sat_sum;
  logic [SB-1:0]   src_sect;
  logic [LEN_W-1:0] src_rem;
  logic [NumDisks-1:0] hit;
  logic            found_n;
  logic [IdxW-1:0] d_n;
  logic [SB:0]     sum_n;
  logic [SB-1:0]   f_rd, b_rd, dev;
  logic            ok, lt;
  logic [LEN_W-1:0] avail, piece, rem_nx;

  logic                emit_ok, emit, load_cap, load_wr, srch_cap, step;
  status_e             e_status;
  logic [DISK_W-1:0]   e_disk;
  logic [SECTOR_W-1:0] e_dev;
  logic [LEN_W-1:0]    e_len;
  logic                e_last;

  assign head_sect = SB'(head_i.sector);
  assign head_size = SB'(head_i.size);
  assign head_off  = SB'(head_i.offset);
  assign hd_idx    = IdxW'(head_i.index);

  // one read port on the end table: previous entry for a load, found disk otherwise
  assign rd_addr  = (state_q == B_IDLE) ? (hd_idx - IdxW'(1)) : d_q;
  assign end_rd   = end_q[rd_addr];
  assign prev_end = (head_i.index == '0) ? '0 : end_rd;
  assign sat_sum  = {1'b0, prev_end} + {1'b0, head_size};
  assign end_n    = sat_sum[SB] ? '1 : sat_sum[SB-1:0];
  assign os_n     = head_off + head_size;

  assign src_sect = (state_q == B_IDLE) ? head_sect : sector_q;
  assign src_rem  = (state_q == B_IDLE) ? head_i.length : remain_q;
  assign sum_n    = {1'b0, src_sect} + (SB+1)'(src_rem);

  always_comb begin
    found_n = 1'b0;
    d_n     = '0;
    for (int i = 0; i < NumDisks; i++) begin
      hit[i] = ((i == 0) || (i < int'(disk_count_i))) && (end_q[i] > src_sect);
    end
    for (int i = NumDisks - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found_n = 1'b1;
        d_n     = IdxW'(i);
      end
    end
  end

  assign f_rd   = first_q[d_q];
  assign b_rd   = base_q[d_q];
  assign ok     = found_q && !bad_q[d_q] && (sector_q >= f_rd);
  assign lt     = (sum_q < {1'b0, end_rd});
  assign avail  = LEN_W'(end_rd - sector_q);
  assign piece  = lt ? remain_q : avail;
  assign rem_nx = lt ? '0 : LEN_W'(sum_q - {1'b0, end_rd});
  assign dev    = sector_q + b_rd;

  assign emit_ok = !out_vq || rsp_o.ready;

  always_comb begin
    state_d    = state_q;
    head_pop_o = 1'b0;
    emit       = 1'b0;
    load_cap   = 1'b0;
    load_wr    = 1'b0;
    srch_cap   = 1'b0;
    step       = 1'b0;
    e_status   = ST_MAPPED;
    e_disk     = '0;
    e_dev      = '0;
    e_len      = '0;
    e_last     = 1'b1;
    case (state_q)
      B_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            K_LOAD: begin
              head_pop_o = 1'b1;
              load_cap   = 1'b1;
              state_d    = B_LOAD;
            end
            K_BARRIER: begin
              if (emit_ok) begin
                head_pop_o = 1'b1;
                emit       = 1'b1;
                e_status   = ST_BARRIER;
              end
            end
            K_MAP: begin
              head_pop_o = 1'b1;
              srch_cap   = 1'b1;
              state_d    = B_PIECE;
            end
            default: begin
              head_pop_o = 1'b1;
            end
          endcase
        end
      end
      B_LOAD: begin
        load_wr = 1'b1;
        state_d = B_IDLE;
      end
      B_SEARCH: begin
        srch_cap = 1'b1;
        state_d  = B_PIECE;
      end
      B_PIECE: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (!ok) begin
            e_status = ST_RANGE;
            e_len    = remain_q;
            state_d  = B_IDLE;
          end else begin
            e_disk = DISK_W'(d_q);
            e_dev  = SECTOR_W'(dev);
            e_len  = piece;
            e_last = (rem_nx == '0);
            if (rem_nx == '0) begin
              state_d = B_IDLE;
            end else begin
              step    = 1'b1;
              state_d = B_SEARCH;
            end
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      out_vq  <= 1'b0;
      bad_q   <= '0;
      for (int i = 0; i < NumDisks; i++) begin
        end_q[i]   <= '0;
        first_q[i] <= '0;
        base_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_vq <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vq <= 1'b0;
      end
      if (load_wr) begin
        end_q[ld_idx_q]   <= ld_end_q;
        first_q[ld_idx_q] <= ld_end_q - ld_size_q;
        base_q[ld_idx_q]  <= ld_os_q - ld_end_q;
        bad_q[ld_idx_q]   <= (ld_size_q > ld_end_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cap) begin
      ld_idx_q  <= hd_idx;
      ld_end_q  <= end_n;
      ld_os_q   <= os_n;
      ld_size_q <= head_size;
    end
    if (srch_cap) begin
      sector_q <= src_sect;
      remain_q <= src_rem;
      sum_q    <= sum_n;
      d_q      <= d_n;
      found_q  <= found_n;
    end else if (step) begin
      sector_q <= end_rd;
      remain_q <= rem_nx;
    end
    if (emit) begin
      st_q   <= e_status;
      dk_q   <= e_disk;
      dev_q  <= e_dev;
      pc_q   <= e_len;
      last_q <= e_last;
    end
  end

  assign rsp_o.valid         = out_vq;
  assign rsp_o.status        = st_q;
  assign rsp_o.disk          = dk_q;
  assign rsp_o.device_sector = dev_q;
  assign rsp_o.piece_sectors = pc_q;
  assign rsp_o.last          = last_q;

  a_search_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SEARCH) |-> (remain_q != '0))
    else $error("split continued with nothing left");

  a_sector_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SEARCH) |-> (sector_q > $past(sector_q)))
    else $error("split did not advance the sector");

  a_found_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_PIECE) && found_q |-> (end_rd > sector_q))
    else $error("found disk ends at or before the sector");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |-> head_valid_i && (state_q == B_IDLE))
    else $error("item taken outside idle");

endmodule

FILE: hw/rtl/linear_concat_sector_mapper.sv
// channel  | dir | modport             | payload
// req_i    | in  | lcsm_req_if.sink    | action, start_lba, length_sectors, barrier,
//          |     |                     | disk_index, disk_size, disk_offset
// rsp_o    | out | lcsm_rsp_if.source  | status, disk, device_sector, piece_sectors, last
// cfg      | in  | cfg_we_i/wdata_i    | disk_count
//
// A map request goes through the back sequencer piece by piece (a search of the
// disk ends in use, then a split), a load through a capture and then a table write,
// and a barrier is answered straight from idle; a two-entry queue lets transfers in
// while the back works. Reset clears the disk table and sets disk_count to one.
// A stalled rsp_o holds the back only; req_i stalls when the queue is full.
module linear_concat_sector_mapper #(
  parameter int NUM_DISKS   = lcsm_pkg::DEF_NUM_DISKS,
  parameter int SECTOR_BITS = lcsm_pkg::DEF_SECTOR_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lcsm_req_if.sink                   req_i,
  lcsm_rsp_if.source                 rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lcsm_pkg::CFG_W-1:0] cfg_wdata_i
);
  import lcsm_pkg::*;

  logic [CFG_W-1:0] count_q, count_d;
  item_t            head;
  logic             head_valid;
  logic             head_pop;

  assign count_d = cfg_we_i ? cfg_wdata_i : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CFG_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  lcsm_front #(
    .NumDisks (NUM_DISKS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .head_pop_i   (head_pop)
  );

  lcsm_back #(
    .NumDisks   (NUM_DISKS),
    .SectorBits (SECTOR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .disk_count_i (count_q),
    .rsp_o        (rsp_o)
  );

endmodule
